@@ rtl/xmbr_pkg.sv @@
// Package with the shared constants and types of the XMODEM block receiver.
`timescale 1ns / 1ps

package xmbr_pkg;

  // Default number of data bytes in one block.
  localparam int unsigned BLOCK_BYTES_DEF = 16;

  // Header codes from the sender.
  localparam logic [7:0] SOH = 8'd1;
  localparam logic [7:0] EOT = 8'd3;
  localparam logic [7:0] CAN = 8'd7;

  // Reply codes to the sender.
  localparam logic [7:0] ACK = 8'd1;
  localparam logic [7:0] NAK = 8'd2;

  // Input function codes.
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_BYTE  = 1'b1;

  // Where the parser stands inside a frame.
  typedef enum logic [2:0] {
    PH_HEADER,
    PH_BLKNUM,
    PH_INVNUM,
    PH_DATA,
    PH_CHECK
  } phase_t;

  // Control sequencer: parsing, or reading the block out of the buffer.
  typedef enum logic [1:0] {
    ST_RUN,
    ST_READ,
    ST_LOAD
  } ctrl_state_t;

endpackage

@@ rtl/xmbr_in_if.sv @@
// Interface of the input channel: function code and received byte.
`timescale 1ns / 1ps

interface xmbr_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] rx_byte;

  modport source (output valid, output func, output rx_byte, input ready);
  modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

@@ rtl/xmbr_out_if.sv @@
// Interface of the result channel: reply codes and data bytes.
`timescale 1ns / 1ps

interface xmbr_out_if;
  logic       valid;
  logic       ready;
  logic       to_driver;
  logic [7:0] value;
  logic       last;

  modport source (output valid, output to_driver, output value, output last, input ready);
  modport sink   (input valid, input to_driver, input value, input last, output ready);
endinterface

@@ rtl/xmbr_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module xmbr_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/xmodem_block_receiver.sv @@
// Top level of the XMODEM block receiver: frame parser, block buffer and result output.
//
//   channel   direction  payload                       handshake
//   in_ch     in         func, rx_byte                 valid / ready
//   out_ch    out        to_driver, value, last        valid / ready
//
// A byte item is taken on a valid and ready handshake; items that give a single reply are
// taken back to back as long as the output register drains.
// A good checksum gives ACK and then BLOCK_BYTES data bytes, each read through the READ
// and LOAD states from the registered block buffer read port; input waits meanwhile.
// Reset (synchronous, rst_n low) returns the parser to the header phase.
// A stalled output holds its item and holds off further input items.
`timescale 1ns / 1ps

module xmodem_block_receiver
  import xmbr_pkg::*;
#(
  parameter int unsigned BLOCK_BYTES = BLOCK_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  xmbr_in_if.sink   in_ch,
  xmbr_out_if.source out_ch
);

  localparam int unsigned CW = $clog2(BLOCK_BYTES + 1);
  localparam int unsigned AW = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;

  phase_t      phase_r, phase_nxt;
  ctrl_state_t st_r, st_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [7:0]  sum_r, sum_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic        out_drv_r, out_drv_nxt;
  logic [7:0]  out_val_r, out_val_nxt;
  logic        out_last_r, out_last_nxt;

  logic        in_fire;
  logic        out_free;
  logic        res_valid;
  logic [7:0]  res_code;
  logic        start_dump;
  logic        wr_en;
  logic        dump_last;
  logic [7:0]  rd_data;
  logic [CW-1:0] cnt_inc;

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign cnt_inc   = cnt_r + CW'(1);
  assign dump_last = (cnt_r == CW'(BLOCK_BYTES - 1));

  xmbr_ram #(
    .WIDTH (8),
    .DEPTH (BLOCK_BYTES),
    .ADDR_W(AW)
  ) u_block_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(cnt_r[AW-1:0]),
    .wr_data(in_ch.rx_byte),
    .rd_addr(cnt_r[AW-1:0]),
    .rd_data(rd_data)
  );

  // Frame parsing and the buffer index, which doubles as the read pointer.
  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    sum_nxt    = sum_r;
    res_valid  = 1'b0;
    res_code   = NAK;
    start_dump = 1'b0;
    wr_en      = 1'b0;
    if (in_fire) begin
      if (in_ch.func == FUNC_START) begin
        phase_nxt = PH_HEADER;
        cnt_nxt   = '0;
        sum_nxt   = '0;
        res_valid = 1'b1;
      end else begin
        case (phase_r)
          PH_HEADER: begin
            // EOT, CAN and any unknown header all answer NAK.
            if (in_ch.rx_byte == SOH) begin
              phase_nxt = PH_BLKNUM;
            end else begin
              res_valid = 1'b1;
            end
          end
          PH_BLKNUM: begin
            phase_nxt = PH_INVNUM;
          end
          PH_INVNUM: begin
            phase_nxt = PH_DATA;
            cnt_nxt   = '0;
            sum_nxt   = '0;
          end
          PH_DATA: begin
            wr_en   = 1'b1;
            sum_nxt = sum_r + in_ch.rx_byte;
            cnt_nxt = cnt_inc;
            if (cnt_inc == CW'(BLOCK_BYTES)) begin
              phase_nxt = PH_CHECK;
            end
          end
          PH_CHECK: begin
            phase_nxt = PH_HEADER;
            cnt_nxt   = '0;
            res_valid = 1'b1;
            if (sum_r == in_ch.rx_byte) begin
              res_code   = ACK;
              start_dump = 1'b1;
            end
          end
          default: begin
            phase_nxt = PH_HEADER;
          end
        endcase
      end
    end else if (st_r == ST_LOAD && out_free) begin
      cnt_nxt = dump_last ? '0 : cnt_inc;
    end
  end

  // Sequencer next state.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_RUN: begin
        if (start_dump) begin
          st_nxt = ST_READ;
        end
      end
      ST_READ: begin
        st_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (out_free) begin
          st_nxt = dump_last ? ST_RUN : ST_READ;
        end
      end
      default: begin
        st_nxt = ST_RUN;
      end
    endcase
  end

  // Sequencer outputs: input ready and the output register load.
  always_comb begin
    in_ch.ready   = (st_r == ST_RUN) && out_free;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_drv_nxt   = out_drv_r;
    out_val_nxt   = out_val_r;
    out_last_nxt  = out_last_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
      out_drv_nxt   = 1'b0;
      out_val_nxt   = res_code;
      out_last_nxt  = !start_dump;
    end else if (st_r == ST_LOAD && out_free) begin
      out_valid_nxt = 1'b1;
      out_drv_nxt   = 1'b1;
      out_val_nxt   = rd_data;
      out_last_nxt  = dump_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      st_r        <= ST_RUN;
      cnt_r       <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_drv_r  <= out_drv_nxt;
    out_val_r  <= out_val_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.to_driver = out_drv_r;
  assign out_ch.value     = out_val_r;
  assign out_ch.last      = out_last_r;

endmodule
